### src/rwc_pkg.sv
// constants, widths and sequencer states of the anti-replay window check
package rwc_pkg;

  localparam int unsigned NONCE_W    = 64;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned TOTAL_BITS = 2048;
  localparam int unsigned WORDS      = TOTAL_BITS / WORD_BITS;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned SLOT_W     = $clog2(WORDS);
  localparam int unsigned CNT_W      = $clog2(WORDS + 1);
  localparam int unsigned SPAN_W     = NONCE_W - BIT_W;

  localparam logic [NONCE_W-1:0] WINDOW      = NONCE_W'(TOTAL_BITS - WORD_BITS);
  localparam logic [NONCE_W-1:0] LIMIT_RESET = 64'd18446744073709549630;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_WINDOW,
    ST_SPAN,
    ST_CLEAR,
    ST_TEST
  } state_e;

endpackage

### src/replay_window_check.sv
// anti-replay window check: counter, ring bitmap and clearing sequencer
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+----------
//  command   | start, nonce_i (busy is out)         | in
//  result    | done_o, accepted_o                   | out
//  config    | reject_limit_we_i, reject_limit_i    | in
//
// the result strobe follows the limit, window, span, clear and test states; the
// clear state wipes each ring word passed over, at most all 32 words, one a cycle
// through the single bitmap write port; busy stays high for all but the strobe cycle
// a rejected item finishes from the limit or window state, skipping clear and test
// reset clears the counter and the whole bitmap at once and loads the limit
// the result strobe lasts one cycle; the receiver cannot stall it
module replay_window_check
  import rwc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [NONCE_W-1:0] nonce_i,
  input  logic               reject_limit_we_i,
  input  logic [NONCE_W-1:0] reject_limit_i,
  output logic               done_o,
  output logic               accepted_o
);

  state_e state_q, state_d;

  logic [NONCE_W-1:0]   limit_q;
  logic [NONCE_W-1:0]   hs_q, hs_d;
  logic [NONCE_W-1:0]   nonce_q;
  logic [NONCE_W-1:0]   pos_q, pos_d;
  logic                 newer_q, newer_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [SLOT_W-1:0]    idx_q, idx_d;
  logic                 done_q, done_d;
  logic                 acc_q, acc_d;
  logic [WORD_BITS-1:0] bitmap_q [WORDS];

  logic                 take;
  logic                 lim_rej;
  logic                 win_rej;
  logic [SPAN_W-1:0]    span;
  logic [SLOT_W-1:0]    slot;
  logic [WORD_BITS-1:0] cur_word;
  logic                 hit;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_slot;
  logic [WORD_BITS-1:0] wr_data;

  assign take = start && !busy;

  assign lim_rej  = (hs_q > limit_q) || (nonce_q >= limit_q);
  assign win_rej  = ({1'b0, pos_q} + {1'b0, WINDOW}) < {1'b0, hs_q};
  assign span     = pos_q[NONCE_W-1:BIT_W] - hs_q[NONCE_W-1:BIT_W];
  assign slot     = pos_q[BIT_W +: SLOT_W];
  assign cur_word = bitmap_q[slot];
  assign hit      = cur_word[pos_q[BIT_W-1:0]];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) state_d = ST_LIMIT;
      end
      ST_LIMIT: begin
        state_d = lim_rej ? ST_IDLE : ST_WINDOW;
      end
      ST_WINDOW: begin
        state_d = win_rej ? ST_IDLE : ST_SPAN;
      end
      ST_SPAN: begin
        state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (cnt_q == '0) state_d = ST_TEST;
      end
      ST_TEST: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath control and outputs
  always_comb begin
    hs_d    = hs_q;
    pos_d   = pos_q;
    newer_d = newer_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    acc_d   = 1'b0;
    wr_en   = 1'b0;
    wr_slot = slot;
    wr_data = cur_word;
    case (state_q)
      ST_IDLE: begin
      end
      ST_LIMIT: begin
        pos_d = nonce_q + NONCE_W'(1);
        if (lim_rej) done_d = 1'b1;
      end
      ST_WINDOW: begin
        newer_d = pos_q > hs_q;
        if (win_rej) done_d = 1'b1;
      end
      ST_SPAN: begin
        cnt_d = '0;
        idx_d = hs_q[BIT_W +: SLOT_W] + SLOT_W'(1);
        if (newer_q) begin
          cnt_d = (span > SPAN_W'(WORDS)) ? CNT_W'(WORDS) : span[CNT_W-1:0];
          hs_d  = pos_q;
        end
      end
      ST_CLEAR: begin
        if (cnt_q != '0) begin
          wr_en   = 1'b1;
          wr_slot = idx_q;
          wr_data = '0;
          idx_d   = idx_q + SLOT_W'(1);
          cnt_d   = cnt_q - CNT_W'(1);
        end
      end
      ST_TEST: begin
        done_d = 1'b1;
        acc_d  = !hit;
        if (!hit) begin
          wr_en   = 1'b1;
          wr_data = cur_word | (WORD_BITS'(1) << pos_q[BIT_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      limit_q <= LIMIT_RESET;
      hs_q    <= '0;
      newer_q <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hs_q    <= hs_d;
      newer_q <= newer_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      acc_q   <= acc_d;
      if (reject_limit_we_i) limit_q <= reject_limit_i;
    end
  end

  // ring bitmap, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WORDS; i++) begin
        bitmap_q[i] <= '0;
      end
    end else if (wr_en) begin
      bitmap_q[wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) nonce_q <= nonce_i;
    pos_q <= pos_d;
  end

  assign busy       = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign accepted_o = acc_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_acc_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted_o |-> done_o)
    else $error("accepted without result strobe");

  a_take_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> busy)
    else $error("transfer taken but sequencer not started");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WORDS))
    else $error("clear count beyond ring size");

  a_hs_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SPAN) |=> $stable(hs_q))
    else $error("counter changed outside update step");

endmodule
